// File: rtl/assert_macros.svh
// Assertion macros shared by the LCD timing and video memory RTL.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LCDM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define LCDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lcdm_pkg.sv
// Types and constants of the LCD mode timing and video memory block.
// No dependencies; used by lcd_mode_timing_and_video_memory.
package lcdm_pkg;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  // Where the read data of an item comes from once it reaches the output.
  typedef enum logic [1:0] {
    SRC_REG    = 2'd0,
    SRC_VRAM   = 2'd1,
    SRC_SPRITE = 2'd2
  } src_t;

  typedef struct packed {
    src_t        src;
    logic [7:0]  reg_byte;
    mode_t       mode;
    logic [7:0]  line;
  } stage_t;

  localparam logic [9:0] OAM_DOTS    = 10'd80;
  localparam logic [9:0] XFER_DOTS   = 10'd172;
  localparam logic [9:0] HBLANK_DOTS = 10'd204;
  localparam logic [9:0] LINE_DOTS   = 10'd456;

  localparam logic [7:0] VBLANK_FIRST_LINE = 8'd144;
  localparam logic [7:0] LAST_LINE         = 8'd153;

  localparam logic [15:0] VRAM_BASE   = 16'h8000;
  localparam logic [15:0] SPRITE_BASE = 16'hFE00;

  localparam logic [15:0] ADDR_LCDC = 16'hFF40;
  localparam logic [15:0] ADDR_STAT = 16'hFF41;
  localparam logic [15:0] ADDR_SCY  = 16'hFF42;
  localparam logic [15:0] ADDR_SCX  = 16'hFF43;
  localparam logic [15:0] ADDR_LY   = 16'hFF44;
  localparam logic [15:0] ADDR_LYC  = 16'hFF45;
  localparam logic [15:0] ADDR_DMA  = 16'hFF46;

  localparam logic [2:0] CFG_LCDC = 3'd0;
  localparam logic [2:0] CFG_STAT = 3'd1;
  localparam logic [2:0] CFG_SCY  = 3'd2;
  localparam logic [2:0] CFG_SCX  = 3'd3;
  localparam logic [2:0] CFG_LYC  = 3'd4;
  localparam logic [2:0] CFG_DMA  = 3'd5;

endpackage

// File: rtl/lcdm_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies; instanced for video RAM and sprite RAM.
module lcdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read data only changes on a read, so it holds while the consumer waits.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/lcd_mode_timing_and_video_memory.sv
// LCD mode timing and video memory: dot/line timing plus video and sprite RAM.
// A result is registered first in the RAM read and stage-one registers, then in the
// output register. Throughput: one item per cycle when the output does not stall,
// set by the single port of each RAM, which serves one read or one write per cycle.
// Reset clears timing state, register values and pipeline valid bits; the
// RAM contents are not cleared and are undefined until written.
module lcd_mode_timing_and_video_memory
  import lcdm_pkg::*;
#(
  parameter int VIDEO_RAM_BYTES  = 8192,
  parameter int SPRITE_RAM_BYTES = 160
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_elapsed_cycles,
  input  logic [15:0] in_bus_address,
  input  logic [7:0]  in_write_data,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic [1:0]  out_current_mode,
  output logic [7:0]  out_current_line
);

  `include "assert_macros.svh"

  localparam int VA_W = (VIDEO_RAM_BYTES > 1) ? $clog2(VIDEO_RAM_BYTES) : 1;
  localparam int SA_W = (SPRITE_RAM_BYTES > 1) ? $clog2(SPRITE_RAM_BYTES) : 1;
  localparam logic [16:0] VRAM_END   = 17'(VRAM_BASE) + 17'(VIDEO_RAM_BYTES);
  localparam logic [16:0] SPRITE_END = 17'(SPRITE_BASE) + 17'(SPRITE_RAM_BYTES);

  // Configuration registers.
  logic [7:0] lcdc_r, stat_r, scy_r, scx_r, lyc_r, dma_r;

  // Timing state.
  mode_t      phase_r, phase_nxt;
  logic [9:0] dot_r, dot_nxt;
  logic [7:0] line_r, line_nxt;
  logic [9:0] dot_sum;
  logic [7:0] line_inc;

  // Pipeline.
  logic   in_accept, s1_adv;
  logic   s1_valid_r;
  stage_t s1_r, s1_nxt;
  logic   out_valid_r;
  logic [7:0] out_read_data_r;
  mode_t      out_mode_r;
  logic [7:0] out_line_r;

  // Address decode.
  func_t      func;
  logic       hit_vram, hit_sprite;
  logic [15:0] vram_off, sprite_off;
  logic [7:0] reg_byte;
  logic       vram_en, sprite_en, is_write;
  logic [7:0] vram_rdata, sprite_rdata;

  assign func      = func_t'(in_func);
  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  assign hit_vram   = (in_bus_address >= VRAM_BASE) && ({1'b0, in_bus_address} < VRAM_END);
  assign hit_sprite = (in_bus_address >= SPRITE_BASE) &&
                      ({1'b0, in_bus_address} < SPRITE_END);
  assign vram_off   = in_bus_address - VRAM_BASE;
  assign sprite_off = in_bus_address - SPRITE_BASE;

  always_comb begin
    unique case (in_bus_address)
      ADDR_LCDC: reg_byte = lcdc_r;
      ADDR_STAT: reg_byte = stat_r;
      ADDR_SCY:  reg_byte = scy_r;
      ADDR_SCX:  reg_byte = scx_r;
      ADDR_LY:   reg_byte = line_r;
      ADDR_LYC:  reg_byte = lyc_r;
      ADDR_DMA:  reg_byte = dma_r;
      default:   reg_byte = 8'd0;
    endcase
  end

  assign is_write  = (func == FUNC_WRITE);
  assign vram_en   = in_accept && (is_write || func == FUNC_READ) && hit_vram;
  assign sprite_en = in_accept && (is_write || func == FUNC_READ) && hit_sprite;

  lcdm_ram #(
    .WIDTH (8),
    .DEPTH (VIDEO_RAM_BYTES)
  ) u_vram (
    .clk   (clk),
    .en    (vram_en),
    .we    (is_write),
    .addr  (vram_off[VA_W-1:0]),
    .wdata (in_write_data),
    .rdata (vram_rdata)
  );

  lcdm_ram #(
    .WIDTH (8),
    .DEPTH (SPRITE_RAM_BYTES)
  ) u_sprite_ram (
    .clk   (clk),
    .en    (sprite_en),
    .we    (is_write),
    .addr  (sprite_off[SA_W-1:0]),
    .wdata (in_write_data),
    .rdata (sprite_rdata)
  );

  // Dot and line timing. Surplus dots are dropped when a phase ends.
  assign dot_sum  = dot_r + {2'b00, in_elapsed_cycles};
  assign line_inc = line_r + 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    dot_nxt   = dot_r;
    line_nxt  = line_r;
    if (in_accept && func == FUNC_TICK) begin
      dot_nxt = dot_sum;
      unique case (phase_r)
        MODE_OAM: begin
          if (dot_sum >= OAM_DOTS) begin
            dot_nxt   = 10'd0;
            phase_nxt = MODE_XFER;
          end
        end
        MODE_XFER: begin
          if (dot_sum >= XFER_DOTS) begin
            dot_nxt   = 10'd0;
            phase_nxt = MODE_HBLANK;
          end
        end
        MODE_HBLANK: begin
          if (dot_sum >= HBLANK_DOTS) begin
            dot_nxt   = 10'd0;
            line_nxt  = line_inc;
            phase_nxt = (line_inc == VBLANK_FIRST_LINE) ? MODE_VBLANK : MODE_OAM;
          end
        end
        default: begin
          if (dot_sum >= LINE_DOTS) begin
            dot_nxt = 10'd0;
            if (line_inc > LAST_LINE) begin
              line_nxt  = 8'd0;
              phase_nxt = MODE_OAM;
            end else begin
              line_nxt = line_inc;
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    s1_nxt.mode     = phase_nxt;
    s1_nxt.line     = line_nxt;
    s1_nxt.reg_byte = 8'd0;
    s1_nxt.src      = SRC_REG;
    if (func == FUNC_READ) begin
      if (hit_vram) begin
        s1_nxt.src = SRC_VRAM;
      end else if (hit_sprite) begin
        s1_nxt.src = SRC_SPRITE;
      end else begin
        s1_nxt.reg_byte = reg_byte;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= MODE_OAM;
      dot_r       <= 10'd0;
      line_r      <= 8'd0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      lcdc_r      <= 8'd0;
      stat_r      <= 8'd0;
      scy_r       <= 8'd0;
      scx_r       <= 8'd0;
      lyc_r       <= 8'd0;
      dma_r       <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      dot_r   <= dot_nxt;
      line_r  <= line_nxt;
      if (!in_stall) begin
        s1_valid_r <= in_accept;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LCDC: lcdc_r <= cfg_wdata;
          CFG_STAT: stat_r <= cfg_wdata;
          CFG_SCY:  scy_r  <= cfg_wdata;
          CFG_SCX:  scx_r  <= cfg_wdata;
          CFG_LYC:  lyc_r  <= cfg_wdata;
          CFG_DMA:  dma_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv && s1_valid_r) begin
      out_mode_r <= s1_r.mode;
      out_line_r <= s1_r.line;
      case (s1_r.src)
        SRC_VRAM:   out_read_data_r <= vram_rdata;
        SRC_SPRITE: out_read_data_r <= sprite_rdata;
        default:    out_read_data_r <= s1_r.reg_byte;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_read_data_r;
  assign out_current_mode = out_mode_r;
  assign out_current_line = out_line_r;

  `LCDM_ASSERT_NOW(a_line_range, 1'b1, line_r <= LAST_LINE, "scanline beyond last line")
  `LCDM_ASSERT_NOW(a_vblank_lines, 1'b1,
    (phase_r == MODE_VBLANK) == (line_r >= VBLANK_FIRST_LINE), "mode and line disagree")
  `LCDM_ASSERT_NOW(a_dot_range, 1'b1, dot_r < LINE_DOTS, "dot counter out of range")
  `LCDM_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_adv, s1_valid_r, "held item was lost")

endmodule
